// ----- rtl/core/sorted_priority_queue_core_defines.svh -----
// assertion macros used by the sorted priority queue top level
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/spq_pkg.sv -----
// types and constants of the sorted priority queue
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCC_W = 5;
  localparam int OUT_TDATA_W = 40;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic ins;
    logic pop;
    key_t key;
  } cell_ctrl_t;

  // one result, status in the lowest bits
  typedef struct packed {
    logic [OCC_W-1:0] occupancy;
    key_t             popped_key;
    spq_status_t      status;
  } result_t;

endpackage

// ----- rtl/core/spq_cell.sv -----
// one slot of the sorted key chain
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  key_t       left_key,
  input  logic       left_take,
  input  key_t       right_key,
  output key_t       key,
  output logic       take
);

  key_t key_r;
  key_t key_nxt;

  // this slot moves right on insert when it is empty or holds a larger key
  assign take = !occupied || (key_r > ctrl.key);

  always_comb begin
    key_nxt = key_r;
    if (ctrl.ins && take) begin
      key_nxt = left_take ? left_key : ctrl.key;
    end else if (ctrl.pop) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key = key_r;

endmodule

// ----- rtl/core/spq_out_buf.sv -----
// two-entry result buffer between the queue and the result channel
module spq_out_buf
  import spq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    ready,
  output logic    valid,
  output result_t data,
  input  logic    take
);

  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  result_t    head_r;
  result_t    head_nxt;
  result_t    skid_r;
  result_t    skid_nxt;
  logic       pop;

  assign ready = (fill_r != 2'd2);
  assign valid = (fill_r != 2'd0);
  assign data  = head_r;
  assign pop   = valid && take;

  always_comb begin
    fill_nxt = fill_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    case (fill_r)
      2'd0: begin
        if (push) begin
          head_nxt = push_data;
          fill_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          skid_nxt = push_data;
          fill_nxt = 2'd2;
        end else if (pop) begin
          fill_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt = skid_r;
          fill_nxt = 2'd1;
        end
      end
      default: begin
        fill_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ----- rtl/core/sorted_priority_queue_core.sv -----
// top level of the sorted minimum priority queue
//
// usage:
//   in channel: one request per beat; in_tuser is the kind (0 insert, 1 pop),
//   in_tdata carries the signed q24.8 key (ignored on pop).
//   out channel: exactly one result per request, in request order; out_tdata
//   holds status (0 ok, 1 pop on empty, 2 insert on full), the popped key
//   (zero unless a pop succeeded) and the count of keys held afterwards.
// throughput:
//   one request per cycle while in_tready is high; the result is registered in
//   the result buffer and reaches the out channel once earlier results are taken.
//   every cell of the key chain compares against the broadcast key in the same
//   cycle and registers its new key from the signed compare and the shift mux.
// stall:
//   a two-entry result buffer lets one more request in while a result waits;
//   with both entries held in_tready drops until the receiver takes one.
// reset:
//   rst_n (synchronous, active low) empties the queue and the result buffer;
//   key slots are not cleared, only slots below the count are ever read.
`include "sorted_priority_queue_core_defines.svh"

module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [KEY_W-1:0]       in_tdata,   // [31:0] key
  input  logic                   in_tuser,   // [0] kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [1:0] status, [33:2] popped_key,
                                             // [38:34] occupancy, [39] zero
);

  cnt_t       count_r;
  cnt_t       count_nxt;
  logic       accept;
  logic       full;
  logic       empty;
  logic       ins_ok;
  logic       pop_ok;
  cell_ctrl_t ctrl;
  result_t    result;
  result_t    buf_data;

  key_t       cell_key  [DEPTH];
  logic       cell_take [DEPTH];
  logic       cell_occ  [DEPTH];

  assign accept = in_tvalid && in_tready;
  assign full   = (count_r == cnt_t'(DEPTH));
  assign empty  = (count_r == '0);
  assign ins_ok = accept && (in_tuser == KIND_INSERT) && !full;
  assign pop_ok = accept && (in_tuser == KIND_POP) && !empty;

  // key and operation broadcast to the whole chain
  assign ctrl.ins = ins_ok;
  assign ctrl.pop = pop_ok;
  assign ctrl.key = key_t'(in_tdata);

  // chain of slots, smallest key in slot 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    key_t left_key;
    logic left_take;
    key_t right_key;

    assign cell_occ[i] = (cnt_t'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_key  = '0;
      assign left_take = 1'b0;
    end else begin : g_mid
      assign left_key  = cell_key[i-1];
      assign left_take = cell_take[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_body
      assign right_key = cell_key[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (cell_occ[i]),
      .left_key  (left_key),
      .left_take (left_take),
      .right_key (right_key),
      .key       (cell_key[i]),
      .take      (cell_take[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + cnt_t'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result of the request taken this cycle
  always_comb begin
    result.status     = ST_OK;
    result.popped_key = '0;
    result.occupancy  = OCC_W'(count_nxt);
    if (in_tuser == KIND_INSERT) begin
      if (full) begin
        result.status = ST_FULL;
      end
    end else begin
      if (empty) begin
        result.status = ST_EMPTY;
      end else begin
        result.popped_key = cell_key[0];
      end
    end
  end

  spq_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .ready     (in_tready),
    .valid     (out_tvalid),
    .data      (buf_data),
    .take      (out_tready)
  );

  assign out_tdata = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, buf_data};

  // count never passes the chain length
  `SPQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= cnt_t'(DEPTH),
    "queue count above depth")

  // an accepted insert on a non-full queue grows the count by one
  `SPQ_ASSERT_NXT(a_ins_grows, clk, rst_n, ins_ok,
    count_r == $past(count_r) + cnt_t'(1), "insert did not grow count")

  // a successful pop shrinks the count by one
  `SPQ_ASSERT_NXT(a_pop_shrinks, clk, rst_n, pop_ok,
    count_r == $past(count_r) - cnt_t'(1), "pop did not shrink count")

  // held keys stay in ascending order along the chain
  for (genvar j = 0; j < DEPTH - 1; j++) begin : g_order_chk
    `SPQ_ASSERT_IMP(a_sorted, clk, rst_n, cnt_t'(j + 1) < count_r,
      cell_key[j] <= cell_key[j+1], "chain keys out of order")
  end

endmodule

// ----- sim/tb_sorted_priority_queue_core.sv -----
// testbench of the sorted minimum priority queue with its own ordered-list predictor
`timescale 1ns / 100ps

module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int RANDOM_REQUESTS = 700;
  localparam int IDLE_LIMIT      = 2000;  // cycles without any handshake
  localparam int DRAIN_CYCLES    = 16;    // margin after the last owed result is taken
  localparam int MAX_GAP         = 12;

  // one row of the directed table; typed rows carry a hand-written result
  typedef struct {
    logic        kind;
    key_t        key;
    bit          typed;
    spq_status_t status;
    key_t        popped_key;
    logic [4:0]  occupancy;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [KEY_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // predictor state: held keys in ascending order, oldest first among equals
  key_t held_keys[$];
  // results still owed by the queue, oldest first
  result_t owed_results[$];
  directed_row_t directed_rows[$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int rx_hold = 0;
  bit rx_steady = 1'b0;  // receiver takes every result at once while set

  sorted_priority_queue_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // insert behind every held key that is less or equal, or pop the front; full or empty is reported
  function automatic result_t apply_request(input logic kind, input key_t key);
    result_t r;
    int pos;
    r.status = ST_OK;
    r.popped_key = '0;
    if (kind == KIND_INSERT) begin
      if (held_keys.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] <= key) pos++;
        held_keys.insert(pos, key);
      end
    end else begin
      if (held_keys.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped_key = held_keys.pop_front();
      end
    end
    r.occupancy = OCC_W'(held_keys.size());
    return r;
  endfunction

  // hand one request to the queue; the result owed is queued at the handshake
  task automatic send_request(input logic kind, input key_t key, input int gap,
                              input bit typed, input result_t typed_result);
    result_t r;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= key;
    do @(posedge clk); while (!in_tready);
    r = apply_request(kind, key);
    owed_results.push_back(typed ? typed_result : r);
  endtask

  task automatic add_row(input logic kind, input key_t key, input bit typed,
                         input spq_status_t status, input key_t popped_key,
                         input logic [4:0] occupancy);
    directed_row_t row;
    row.kind = kind;
    row.key = key;
    row.typed = typed;
    row.status = status;
    row.popped_key = popped_key;
    row.occupancy = occupancy;
    directed_rows.push_back(row);
  endtask

  // receiver: a fresh random stall of up to MAX_GAP after each result it takes, none while rx_steady is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold = 0;
    end else if (out_tvalid && out_tready) begin
      rx_hold = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      out_tready <= (rx_hold == 0);
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= (rx_hold == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker: every result against the oldest owed one, field by field
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result", 40'(out_tdata), '0);
      end else begin
        want = owed_results.pop_front();
        if (out_tdata[1:0] !== want.status)
          report_mismatch("status", 40'(out_tdata[1:0]), 40'(want.status));
        if (out_tdata[33:2] !== want.popped_key)
          report_mismatch("popped key", 40'(out_tdata[33:2]), 40'(want.popped_key));
        if (out_tdata[38:34] !== want.occupancy)
          report_mismatch("occupancy", 40'(out_tdata[38:34]), 40'(want.occupancy));
        if (out_tdata[39] !== 1'b0)
          report_mismatch("pad bit", 40'(out_tdata[39]), '0);
      end
    end
  end

  // watchdog: ends a run in which no handshake happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sorted_priority_queue_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    result_t typed_result;
    logic kind;
    key_t key;
    int sent;
    int burst_len;
    int insert_pct;
    bit no_gaps;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: empty pop, extremes, equal keys, filling up, full insert
    add_row(KIND_POP,    32'sh5A5A_A5A5, 1'b1, ST_EMPTY, '0, 5'd0);
    add_row(KIND_INSERT, 32'sh7FFF_FFFF, 1'b1, ST_OK,    '0, 5'd1);
    add_row(KIND_INSERT, 32'sh8000_0000, 1'b1, ST_OK,    '0, 5'd2);
    add_row(KIND_INSERT, 32'sh0000_0000, 1'b0, ST_OK,    '0, 5'd0);
    add_row(KIND_INSERT, 32'sh0000_0000, 1'b0, ST_OK,    '0, 5'd0);
    add_row(KIND_INSERT, 32'shFFFF_FFFF, 1'b0, ST_OK,    '0, 5'd0);
    add_row(KIND_POP,    32'shA5A5_5A5A, 1'b1, ST_OK,    32'sh8000_0000, 5'd4);
    for (int i = 0; i < 12; i++) begin
      // alternating signs and growing magnitudes; the last one is the most negative key
      key = 32'sh1 <<< (2 * i + 9);
      add_row(KIND_INSERT, (i % 2) ? -key : key, 1'b0, ST_OK, '0, 5'd0);
    end
    add_row(KIND_INSERT, 32'sh0000_0100, 1'b1, ST_FULL, '0, 5'd16);
    add_row(KIND_POP,    32'shFFFF_FFFF, 1'b0, ST_OK,   '0, 5'd0);
    add_row(KIND_INSERT, 32'sh7FFF_FFFF, 1'b0, ST_OK,   '0, 5'd0);

    foreach (directed_rows[i]) begin
      typed_result.status = directed_rows[i].status;
      typed_result.popped_key = directed_rows[i].popped_key;
      typed_result.occupancy = directed_rows[i].occupancy;
      send_request(directed_rows[i].kind, directed_rows[i].key,
                   $urandom_range(0, MAX_GAP), directed_rows[i].typed, typed_result);
    end

    // random bursts leaning toward inserts, toward pops or even, so the queue swings
    // between empty and full; some bursts run without any idling
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst_len = $urandom_range(4, 40);
      case ($urandom_range(0, 2))
        0: insert_pct = 20;
        1: insert_pct = 50;
        default: insert_pct = 85;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < burst_len && sent < RANDOM_REQUESTS; j++) begin
        kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_POP;
        case ($urandom_range(0, 3))
          0, 1: key = key_t'($urandom);
          2: key = key_t'(int'($urandom_range(0, 16)) - 8);  // many equal keys
          default: begin
            case ($urandom_range(0, 3))
              0: key = 32'sh7FFF_FFFF;
              1: key = 32'sh8000_0000;
              2: key = 32'sh0000_0000;
              default: key = 32'shFFFF_FFFF;
            endcase
          end
        endcase
        send_request(kind, key, no_gaps ? 0 : $urandom_range(0, MAX_GAP), 1'b0, '0);
        sent++;
      end
    end
    in_tvalid <= 1'b0;
    rx_steady = 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("sorted_priority_queue_core verification clean");
    end else begin
      $display("sorted_priority_queue_core verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/spq_out_buf.sv
rtl/core/sorted_priority_queue_core.sv
sim/tb_sorted_priority_queue_core.sv
